### rtl/mls_pkg.sv
// ----------------------------------------------------------------------------
// mls_pkg
// Shared codes, register indexes and constants of the marker landing servo.
// ----------------------------------------------------------------------------
package mls_pkg;

   typedef enum logic [2:0] {
      ACT_ENTER  = 3'd0,
      ACT_EXIT   = 3'd1,
      ACT_TICK   = 3'd2,
      ACT_MARKER = 3'd3,
      ACT_LIDAR  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      TR_NONE    = 2'd0,
      TR_LOST    = 2'd1,
      TR_DELIVER = 2'd2
   } transition_type;

   localparam logic [2:0] CSR_BOX_THRESHOLD   = 3'd0;
   localparam logic [2:0] CSR_LOST_TICKS      = 3'd1;
   localparam logic [2:0] CSR_TARGET_HEIGHT   = 3'd2;
   localparam logic [2:0] CSR_MAX_HEIGHT_STEP = 3'd3;
   localparam logic [2:0] CSR_SETTLE_TICKS    = 3'd4;

   localparam logic [14:0] BOX_THRESHOLD_RST   = 15'd512;
   localparam logic [31:0] LOST_TICKS_RST      = 32'd5000;
   localparam logic [14:0] TARGET_HEIGHT_RST   = 15'd1280;
   localparam logic [14:0] MAX_HEIGHT_STEP_RST = 15'd512;
   localparam logic [31:0] SETTLE_TICKS_RST    = 32'd2500;

   localparam logic [15:0] NO_LIDAR_RANGE = 16'sd1;
   localparam logic [31:0] AGE_MAX        = 32'hFFFF_FFFF;

   // cm to Q8.8 m is range * 64 / 25; range * ceil(2^26/25) >> 20 is exact
   // for every 15-bit range
   localparam logic [21:0] CM_TO_Q88_MUL = 22'd2684355;

endpackage

### rtl/marker_landing_servo.sv
// ----------------------------------------------------------------------------
// marker_landing_servo
// Visual-servo descent controller: marker, lidar and tick transactions in,
// one move command / transition result out for every transaction.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock unless stalled and returns exactly
// one result for each, through the input register and the result register;
// the rate is set by the combinational update of the controller state between
// them. A lidar sample is converted to Q8.8 metres by one multiply when it
// arrives and the converted height is held for later marker samples. Either
// side may stall at any time; the result register and the input register form
// a two-entry pipeline, so a waiting result still lets one new transaction in.
// Configuration must be written through the csr_ port while the block is idle
// (the block does not enforce this) and takes effect on the next transaction.
module marker_landing_servo (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // marker_x, marker_y, marker_z, range_cm
   input  logic [2:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // move_x, move_y, move_z
   output logic [2:0]  rsp_tuser,   // move_valid, transition
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import mls_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   logic [2:0]  s1_action_ff;
   logic [15:0] s1_x_ff, s1_y_ff, s1_z_ff, s1_range_ff;

   logic [14:0] box_ff, target_ff, step_ff;
   logic [31:0] lost_ff, settle_ff;

   logic        active_ff, active_in;
   logic        stable_ff, stable_in;
   logic        nolidar_ff, nolidar_in;
   logic [16:0] est_ff, est_in;
   logic [31:0] marker_age_ff, marker_age_in;
   logic [31:0] stable_age_ff, stable_age_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_user_ff, rsp_user_in;

   logic        advance, fire;
   logic [36:0] est_prod;

   logic signed [16:0] mx_s, my_s;
   logic [16:0]        ax, ay;
   logic [19:0]        ax10, ay10;
   logic signed [18:0] est_s, zdiff, step_s, step_neg, zclamp;
   logic [15:0]        zc, zmag;
   logic [17:0]        zmag4;
   logic               in_box, tight;
   logic [31:0]        age_inc;
   logic               move_valid;
   logic [15:0]        move_z;
   transition_type     tr;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign fire       = s1_valid_ff && advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // datapath
   assign est_prod = s1_range_ff[14:0] * CM_TO_Q88_MUL;

   assign mx_s = {s1_x_ff[15], s1_x_ff};
   assign my_s = {s1_y_ff[15], s1_y_ff};
   assign ax   = s1_x_ff[15] ? 17'(-mx_s) : 17'(mx_s);
   assign ay   = s1_y_ff[15] ? 17'(-my_s) : 17'(my_s);
   assign ax10 = {ax, 3'b000} + {2'b00, ax, 1'b0};
   assign ay10 = {ay, 3'b000} + {2'b00, ay, 1'b0};

   assign in_box = (ax < {2'b00, box_ff}) && (ay < {2'b00, box_ff});

   assign est_s    = nolidar_ff ? {{3{s1_z_ff[15]}}, s1_z_ff} : {2'b00, est_ff};
   assign zdiff    = signed'({4'b0000, target_ff}) - est_s;
   assign step_s   = signed'({4'b0000, step_ff});
   assign step_neg = -step_s;

   always_comb begin
      if (zdiff < step_neg) begin
         zclamp = step_neg;
      end else if (zdiff > step_s) begin
         zclamp = step_s;
      end else begin
         zclamp = zdiff;
      end
   end

   assign zc    = zclamp[15:0];
   assign zmag  = zc[15] ? 16'(-zc) : zc;
   assign zmag4 = {zmag, 2'b00};
   assign tight = (ax10 < {5'b00000, box_ff}) && (ay10 < {5'b00000, box_ff})
                  && (zmag4 < {3'b000, box_ff});

   assign age_inc = (marker_age_ff == AGE_MAX) ? marker_age_ff : marker_age_ff + 32'd1;

   // controller state
   always_comb begin
      active_in     = active_ff;
      stable_in     = stable_ff;
      nolidar_in    = nolidar_ff;
      est_in        = est_ff;
      marker_age_in = marker_age_ff;
      stable_age_in = stable_age_ff;
      move_valid    = 1'b0;
      move_z        = '0;
      tr            = TR_NONE;
      case (s1_action_ff)
         ACT_ENTER: begin
            active_in     = 1'b1;
            stable_in     = 1'b0;
            marker_age_in = '0;
         end
         ACT_EXIT: begin
            active_in = 1'b0;
            stable_in = 1'b0;
         end
         ACT_TICK: begin
            if (active_ff) begin
               marker_age_in = age_inc;
               if (stable_ff && stable_age_ff != AGE_MAX) begin
                  stable_age_in = stable_age_ff + 32'd1;
               end
               if (age_inc > lost_ff) begin
                  tr = TR_LOST;
               end
            end
         end
         ACT_LIDAR: begin
            nolidar_in = s1_range_ff[15] || (s1_range_ff == NO_LIDAR_RANGE);
            est_in     = est_prod[36:20];
         end
         ACT_MARKER: begin
            if (active_ff) begin
               marker_age_in = '0;
               move_valid    = 1'b1;
               if (in_box) begin
                  if (tight) begin
                     stable_in = 1'b1;
                     if (!stable_ff) begin
                        stable_age_in = '0;
                     end else if (stable_age_ff > settle_ff) begin
                        tr        = TR_DELIVER;
                        active_in = 1'b0;
                     end
                  end else begin
                     stable_in = 1'b0;
                     move_z    = zc;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = move_valid ? {move_z, s1_y_ff, s1_x_ff} : '0;
         rsp_user_in  = {tr, move_valid};
      end
   end

   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         active_ff     <= 1'b0;
         stable_ff     <= 1'b0;
         nolidar_ff    <= 1'b1;
         est_ff        <= '0;
         marker_age_ff <= '0;
         stable_age_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            active_ff     <= active_in;
            stable_ff     <= stable_in;
            nolidar_ff    <= nolidar_in;
            est_ff        <= est_in;
            marker_age_ff <= marker_age_in;
            stable_age_ff <= stable_age_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_action_ff <= req_tuser;
         s1_x_ff      <= req_tdata[15:0];
         s1_y_ff      <= req_tdata[31:16];
         s1_z_ff      <= req_tdata[47:32];
         s1_range_ff  <= req_tdata[63:48];
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff    <= BOX_THRESHOLD_RST;
         lost_ff   <= LOST_TICKS_RST;
         target_ff <= TARGET_HEIGHT_RST;
         step_ff   <= MAX_HEIGHT_STEP_RST;
         settle_ff <= SETTLE_TICKS_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BOX_THRESHOLD:   box_ff    <= csr_wdata[14:0];
            CSR_LOST_TICKS:      lost_ff   <= csr_wdata;
            CSR_TARGET_HEIGHT:   target_ff <= csr_wdata[14:0];
            CSR_MAX_HEIGHT_STEP: step_ff   <= csr_wdata[14:0];
            CSR_SETTLE_TICKS:    settle_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

### rtl/mls_checker.sv
// ----------------------------------------------------------------------------
// mls_checker
// Port-level checks of the marker landing servo result channel.
// ----------------------------------------------------------------------------
module mls_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import mls_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_no_move_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("move fields not zero without a move command");

   a_deliver: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] == TR_DELIVER |-> rsp_tuser[0] && rsp_tdata[47:32] == '0)
      else $error("deliver without a level move command");

   a_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] == TR_LOST |-> !rsp_tuser[0])
      else $error("lost marker together with a move command");

endmodule

bind marker_landing_servo mls_checker u_mls_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### bench/marker_landing_servo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marker_landing_servo_checker
// Watches the request, result and register write ports of the landing servo.
// Every accepted request runs through an independent model of the descent
// controller. The model's move command goes into an in-order queue, and each
// accepted result is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module marker_landing_servo_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import mls_pkg::*;

   localparam int PRINT_LIMIT = 60;

   typedef struct packed {
      logic           move_valid;
      logic [15:0]    move_x;
      logic [15:0]    move_y;
      logic [15:0]    move_z;
      transition_type transition;
   } move_cmd_type;

   logic [14:0] box_half;
   logic [31:0] lost_limit;
   logic [14:0] height_goal;
   logic [14:0] step_cap;
   logic [31:0] settle_limit;

   logic        engaged;
   logic        held_steady;
   logic [15:0] lidar_cm;
   logic [31:0] marker_age;
   logic [31:0] steady_age;

   move_cmd_type pending_moves[$];

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      if (fail_count < PRINT_LIMIT)
         $display("%0t ns: mismatch on %s: got %h, want %h", $realtime, field, got, want);
      fail_count++;
   endtask

   function automatic logic [31:0] bump_age(input logic [31:0] age);
      return (age == AGE_MAX) ? age : age + 32'd1;
   endfunction

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   task automatic servo_step(input logic [2:0] act, input logic signed [15:0] mx,
                             input logic signed [15:0] my, input logic signed [15:0] mz,
                             input logic signed [15:0] rc, output move_cmd_type cmd);
      int ax;
      int ay;
      int lim;
      int height;
      int corr;
      int cap;
      cmd = '0;
      cmd.transition = TR_NONE;
      case (act)
         ACT_ENTER: begin
            engaged     = 1'b1;
            held_steady = 1'b0;
            marker_age  = '0;
         end
         ACT_EXIT: begin
            engaged     = 1'b0;
            held_steady = 1'b0;
         end
         ACT_TICK: begin
            if (engaged) begin
               marker_age = bump_age(marker_age);
               if (held_steady)
                  steady_age = bump_age(steady_age);
               if (marker_age > lost_limit)
                  cmd.transition = TR_LOST;
            end
         end
         ACT_LIDAR: begin
            lidar_cm = (rc < 0) ? NO_LIDAR_RANGE : rc;
         end
         ACT_MARKER: begin
            if (engaged) begin
               lim        = int'(box_half);
               ax         = magnitude(int'(mx));
               ay         = magnitude(int'(my));
               corr       = 0;
               marker_age = '0;
               if (ax < lim && ay < lim) begin
                  height = (lidar_cm != NO_LIDAR_RANGE) ? int'(lidar_cm) * 64 / 25
                                                        : int'(mz);
                  cap    = int'(step_cap);
                  corr   = int'(height_goal) - height;
                  if (corr < -cap)
                     corr = -cap;
                  if (corr > cap)
                     corr = cap;
                  if (10 * ax < lim && 10 * ay < lim && 4 * magnitude(corr) < lim) begin
                     corr = 0;
                     if (!held_steady) begin
                        steady_age  = '0;
                        held_steady = 1'b1;
                     end
                     if (steady_age > settle_limit) begin
                        cmd.transition = TR_DELIVER;
                        engaged        = 1'b0;
                     end
                  end else begin
                     held_steady = 1'b0;
                  end
               end
               cmd.move_valid = 1'b1;
               cmd.move_x     = mx;
               cmd.move_y     = my;
               cmd.move_z     = corr[15:0];
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : monitor
      move_cmd_type want;
      if (reset) begin
         box_half     = BOX_THRESHOLD_RST;
         lost_limit   = LOST_TICKS_RST;
         height_goal  = TARGET_HEIGHT_RST;
         step_cap     = MAX_HEIGHT_STEP_RST;
         settle_limit = SETTLE_TICKS_RST;
         engaged      = 1'b0;
         held_steady  = 1'b0;
         lidar_cm     = NO_LIDAR_RANGE;
         marker_age   = '0;
         steady_age   = '0;
         pending_moves.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_moves.size() == 0) begin
               report_mismatch("result with nothing outstanding", rsp_tdata[15:0], '0);
            end else begin
               want = pending_moves.pop_front();
               if (rsp_tuser[0] !== want.move_valid)
                  report_mismatch("move_valid", 16'(rsp_tuser[0]), 16'(want.move_valid));
               if (rsp_tdata[15:0] !== want.move_x)
                  report_mismatch("move_x", rsp_tdata[15:0], want.move_x);
               if (rsp_tdata[31:16] !== want.move_y)
                  report_mismatch("move_y", rsp_tdata[31:16], want.move_y);
               if (rsp_tdata[47:32] !== want.move_z)
                  report_mismatch("move_z", rsp_tdata[47:32], want.move_z);
               if (rsp_tuser[2:1] !== want.transition)
                  report_mismatch("transition", 16'(rsp_tuser[2:1]), 16'(want.transition));
            end
         end
         if (req_tvalid && req_tready) begin
            servo_step(req_tuser, req_tdata[15:0], req_tdata[31:16], req_tdata[47:32],
                       req_tdata[63:48], want);
            pending_moves.push_back(want);
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_BOX_THRESHOLD:   box_half     = csr_wdata[14:0];
               CSR_LOST_TICKS:      lost_limit   = csr_wdata;
               CSR_TARGET_HEIGHT:   height_goal  = csr_wdata[14:0];
               CSR_MAX_HEIGHT_STEP: step_cap     = csr_wdata[14:0];
               CSR_SETTLE_TICKS:    settle_limit = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = pending_moves.size();
   end

endmodule

### bench/marker_landing_servo_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marker_landing_servo_tb
// Stimulus and verdict for the landing servo. A short directed run covers the
// field extremes, every action, undefined codes, lidar special values, lost
// and deliver. Random phases follow under changing register settings and
// handshake pressure, mostly enter-marker-tick runs that settle onto the
// marker, mixed with noise. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module marker_landing_servo_tb;
   import mls_pkg::*;

   localparam int  PHASES        = 6;
   localparam int  PHASE_ITEMS   = 117;
   localparam int  LONG_STALL    = 300;
   localparam int  DRAIN_LIMIT   = 20000;
   localparam int  QUIET_CYCLES  = 6;
   localparam time RUN_LIMIT_NS  = 4_000_000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [31:0] csr_wdata;

   int fail_count;
   int pending;
   int tx_idle_pct;
   int rx_stall_pct;
   int items_sent;
   int box_now;
   int goal_now;
   logic hold_off;

   marker_landing_servo dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   marker_landing_servo_checker servo_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // result side: random stalls, or one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   function automatic logic [15:0] rand16();
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] around(input int center, input int spread);
      return 16'(center + int'($urandom_range(0, 2 * spread + 2)) - spread - 1);
   endfunction

   task automatic send_item(input logic [2:0] act, input logic [15:0] x,
                            input logic [15:0] y, input logic [15:0] z,
                            input logic [15:0] r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {r, z, y, x};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_config(input logic [31:0] box, input logic [31:0] lost,
                               input logic [31:0] goal, input logic [31:0] cap,
                               input logic [31:0] settle);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_BOX_THRESHOLD;
      csr_wdata <= box;
      @(negedge clock);
      csr_addr  <= CSR_LOST_TICKS;
      csr_wdata <= lost;
      @(negedge clock);
      csr_addr  <= CSR_TARGET_HEIGHT;
      csr_wdata <= goal;
      @(negedge clock);
      csr_addr  <= CSR_MAX_HEIGHT_STEP;
      csr_wdata <= cap;
      @(negedge clock);
      csr_addr  <= CSR_SETTLE_TICKS;
      csr_wdata <= settle;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
      box_now  = int'(box[14:0]);
      goal_now = int'(goal[14:0]);
   endtask

   task automatic send_near_marker();
      send_item(ACT_MARKER, around(0, box_now / 10), around(0, box_now / 10),
                around(goal_now, box_now / 4), rand16());
   endtask

   task automatic send_near_lidar();
      send_item(ACT_LIDAR, rand16(), rand16(), rand16(), around(goal_now * 25 / 64, 2));
   endtask

   // enter, settle onto the marker, tick; a little noise in between
   task automatic run_landing();
      int steps;
      int pick;
      send_item(ACT_ENTER, rand16(), rand16(), rand16(), rand16());
      case ($urandom_range(3))
         0: send_near_lidar();
         1: send_item(ACT_LIDAR, rand16(), rand16(), rand16(), 16'(-int'($urandom_range(1, 32768))));
         2: send_item(ACT_LIDAR, rand16(), rand16(), rand16(), NO_LIDAR_RANGE);
         default: ;
      endcase
      steps = $urandom_range(3, 14);
      repeat (steps) begin
         pick = $urandom_range(99);
         if (pick < 40)
            send_item(ACT_TICK, rand16(), rand16(), rand16(), rand16());
         else if (pick < 85)
            send_near_marker();
         else if (pick < 90)
            send_item(ACT_MARKER, rand16(), rand16(), rand16(), rand16());
         else if (pick < 95)
            send_item(ACT_LIDAR, rand16(), rand16(), rand16(), rand16());
         else
            send_item(3'($urandom_range(1, 7)), rand16(), rand16(), rand16(), rand16());
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = ACT_ENTER;
      csr_we       = 1'b0;
      csr_addr     = CSR_BOX_THRESHOLD;
      csr_wdata    = '0;
      hold_off     = 1'b0;
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      items_sent   = 0;
      box_now      = int'(BOX_THRESHOLD_RST);
      goal_now     = int'(TARGET_HEIGHT_RST);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults after reset
      send_item(ACT_MARKER, 16'h7FFF, 16'h8000, 16'd1280, 16'h0000);
      for (int k = ACT_LIDAR + 1; k < 8; k++)
         send_item(3'(k), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(ACT_TICK, '0, '0, '0, '0);
      send_item(ACT_LIDAR, '0, '0, '0, 16'(-5));
      send_item(ACT_ENTER, '0, '0, '0, '0);
      send_item(ACT_MARKER, 16'd100, 16'(-100), 16'd1280, '0);
      send_item(ACT_MARKER, 16'd40, 16'(-40), 16'd1280, '0);
      send_item(ACT_MARKER, 16'h8000, 16'h7FFF, 16'd1280, '0);
      send_item(ACT_LIDAR, '0, '0, '0, 16'd0);
      send_item(ACT_MARKER, 16'd10, 16'd10, 16'h8000, '0);
      send_item(ACT_LIDAR, '0, '0, '0, 16'h7FFF);
      send_item(ACT_MARKER, '0, '0, '0, '0);
      send_item(ACT_LIDAR, '0, '0, '0, NO_LIDAR_RANGE);
      send_item(ACT_MARKER, '0, '0, 16'h7FFF, '0);
      send_item(ACT_LIDAR, '0, '0, '0, 16'h8000);
      send_item(ACT_EXIT, '0, '0, '0, '0);
      send_item(ACT_TICK, '0, '0, '0, '0);
      drain();

      // widest box, fast lost and deliver
      write_config(32'hFFFF_FFFF, 32'd2, 32'd1000, 32'd300, 32'd1);
      send_item(ACT_ENTER, '0, '0, '0, '0);
      send_item(ACT_MARKER, '0, '0, 16'd1000, '0);
      send_item(ACT_TICK, '0, '0, '0, '0);
      send_item(ACT_TICK, '0, '0, '0, '0);
      send_item(ACT_TICK, '0, '0, '0, '0);
      send_item(ACT_MARKER, 16'd5, 16'(-5), 16'd1000, '0);
      send_item(ACT_TICK, '0, '0, '0, '0);
      send_item(ACT_MARKER, 16'd5, 16'd5, 16'd1000, '0);
      send_item(ACT_EXIT, '0, '0, '0, '0);

      items_sent = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: write_config(32'd4000, 32'd8, 32'd1280, 32'd512, 32'd3);
            1: write_config(32'd32767, 32'd0, 32'd0, 32'd0, 32'd0);
            2: write_config(32'd0, 32'hFFFF_FFFF, 32'd32767, 32'd32767, 32'hFFFF_FFFF);
            3: write_config($urandom_range(600, 12000), $urandom_range(0, 16), $urandom,
                            $urandom, $urandom_range(0, 6));
            4: write_config($urandom_range(2000, 32767), $urandom_range(0, 40),
                            $urandom_range(0, 32767), $urandom_range(0, 600),
                            $urandom_range(0, 3));
            default: write_config($urandom, $urandom_range(4, 30), $urandom,
                                  $urandom_range(0, 2000), $urandom_range(0, 8));
         endcase
         case (phase)
            1, 5: begin
               tx_idle_pct  = 59;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 59;
               hold_off     = 1'b1;
            end
            3: begin
               tx_idle_pct  = 14;
               rx_stall_pct = 14;
            end
            default: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
            end
         endcase
         while (items_sent < PHASE_ITEMS * (phase + 1)) begin
            if ($urandom_range(99) < 75)
               run_landing();
            else
               send_item(3'($urandom_range(0, 7)), rand16(), rand16(), rand16(), rand16());
         end
      end

      drain();
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
